### rtl/thb_pkg.sv
// ----------------------------------------------------------------------------
// thb_pkg
// Shared constants and types for the triangle hit / barycentric UV core.
// ----------------------------------------------------------------------------
package thb_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int TEX_BITS_DEF   = 32;

  // operand slice width of the pipelined multiplier (25x25 signed pieces)
  localparam int MUL_PIECE = 24;

  // quotient bits kept by the divider; quotients above 2**QUO_LIM_LOG2 saturate
  localparam int QUO_BITS     = 41;
  localparam int QUO_LIM_LOG2 = 40;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_VERTEX_C = 3'd2,
    REG_TEX_A    = 3'd3,
    REG_TEX_B    = 3'd4,
    REG_TEX_C    = 3'd5,
    REG_HIT_TOL  = 3'd6
  } cfg_reg_t;

  localparam logic [63:0] VERTEX_A_RST = 64'd0;
  localparam logic [63:0] VERTEX_B_RST = 64'd4096;
  localparam logic [63:0] VERTEX_C_RST = 64'd4294967296;
  localparam logic [63:0] TEX_A_RST    = 64'd0;
  localparam logic [63:0] TEX_B_RST    = 64'd65536;
  localparam logic [63:0] TEX_C_RST    = 64'd281474976710656;
  localparam logic [31:0] HIT_TOL_RST  = 32'd16;

endpackage

### rtl/thb_smul.sv
// ----------------------------------------------------------------------------
// thb_smul
// Two-stage signed multiplier: partial products of narrow slices are
// registered, then shifted and summed into the full product.
// ----------------------------------------------------------------------------
module thb_smul #(
  parameter int AW = 44,
  parameter int BW = 44
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW = thb_pkg::MUL_PIECE;
  localparam int NA = (AW + PW - 1) / PW;
  localparam int NB = (BW + PW - 1) / PW;
  localparam int XA = NA * PW;
  localparam int XB = NB * PW;
  localparam int SW = XA + XB;

  logic signed [XA-1:0]     ax;
  logic signed [XB-1:0]     bx;
  logic signed [2*PW+1:0]   pp_r [NA][NB];
  logic signed [SW-1:0]     acc;
  logic signed [AW+BW-1:0]  p_r;

  assign ax = XA'(a);
  assign bx = XB'(b);

  // lower slices are unsigned, the top slice carries the sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= $signed({((i == NA - 1) ? ax[XA-1] : 1'b0), ax[i*PW +: PW]}) *
                        $signed({((j == NB - 1) ? bx[XB-1] : 1'b0), bx[j*PW +: PW]});
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_r[i][j]) << ((i + j) * PW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule

### rtl/triangle_hit_and_barycentric_uv_core.sv
// ----------------------------------------------------------------------------
// triangle_hit_and_barycentric_uv_core
// Point-in-triangle test by sub-triangle areas and barycentric texture
// interpolation, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | in_tdata: point x, y, z
//  out_    | out | out_tvalid/out_tready | out_tdata: inside, degenerate, u, v
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One point per cycle while the output is not stalled; the square root and divider
//  chains produce one result bit per stage.
//  Reset (rst_n low, synchronous) empties the pipeline and loads default regs.
//  A stalled output freezes the whole pipeline; in_tready = !out_tvalid | out_tready.
//  cfg_ready is always high; registers are read live by the stages that use them.
// ----------------------------------------------------------------------------
module triangle_hit_and_barycentric_uv_core #(
  parameter int COORD_BITS = thb_pkg::COORD_BITS_DEF,
  parameter int TEX_BITS   = thb_pkg::TEX_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // point_x, point_y, point_z (COORD_BITS each), zero pad
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]         in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // inside_res, degenerate, tex_u, tex_v (TEX_BITS each), zero pad
  output logic [((2+2*TEX_BITS+7)/8)*8-1:0]         out_tdata,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [thb_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [63:0]                               cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int TB    = TEX_BITS;
  localparam int OUT_W = ((2 + 2 * TEX_BITS + 7) / 8) * 8;
  localparam int VXW   = (3 * CB > 64) ? 3 * CB : 64;
  localparam int DW    = CB + 1;
  localparam int CRW   = 2 * DW + 1;
  localparam int SQW   = 2 * CRW;
  localparam int NW    = SQW + 2;
  localparam int RW    = NW / 2;
  localparam int REMW  = RW + 2;
  localparam int TWW   = RW + 4;
  localparam int AW2   = ((RW > 32) ? RW : 32) + 2;
  localparam int DTW   = 2 * DW + 2;
  localparam int DMW   = 2 * DTW;
  localparam int DNS   = DMW + 1;
  localparam int DENW  = DMW;
  localparam int TDW   = TB + 1;
  localparam int NUMW  = DNS + TDW + 1;
  localparam int XW    = NUMW + 1;
  localparam int QB    = thb_pkg::QUO_BITS;
  localparam int RXW   = TB + QB + 2;
  localparam int L     = 10 + RW + QB;

  localparam logic [QB-1:0] QLIM = QB'(1) << thb_pkg::QUO_LIM_LOG2;
  localparam logic signed [RXW-1:0] TMAX = RXW'((64'sd1 <<< (TB - 1)) - 64'sd1);
  localparam logic signed [RXW-1:0] TMIN = -TMAX - RXW'(1);

  // cross product operand pairs: (qa,qb) (qa,qc) (qb,qc) (e0,e1)
  localparam int CP_A [4] = '{0, 0, 1, 3};
  localparam int CP_B [4] = '{1, 2, 2, 4};
  // dot products d00 d01 d11 d20 d21
  localparam int DP_A [5] = '{3, 3, 4, 5, 5};
  localparam int DP_B [5] = '{3, 4, 4, 3, 4};
  // determinant and numerator products
  localparam int DM_A [6] = '{0, 1, 2, 1, 0, 1};
  localparam int DM_B [6] = '{2, 1, 3, 4, 4, 3};

  logic en;
  logic [L-1:0] v_r;

  assign en         = !v_r[L-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[L-1];
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[L-2:0], in_tvalid};
    end
  end

  // ---------------- configuration registers ----------------
  logic [63:0] vtx_r [3];
  logic [63:0] tex_r [3];
  logic [31:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_r[0] <= thb_pkg::VERTEX_A_RST;
      vtx_r[1] <= thb_pkg::VERTEX_B_RST;
      vtx_r[2] <= thb_pkg::VERTEX_C_RST;
      tex_r[0] <= thb_pkg::TEX_A_RST;
      tex_r[1] <= thb_pkg::TEX_B_RST;
      tex_r[2] <= thb_pkg::TEX_C_RST;
      tol_r    <= thb_pkg::HIT_TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        thb_pkg::REG_VERTEX_A: vtx_r[0] <= cfg_data;
        thb_pkg::REG_VERTEX_B: vtx_r[1] <= cfg_data;
        thb_pkg::REG_VERTEX_C: vtx_r[2] <= cfg_data;
        thb_pkg::REG_TEX_A:    tex_r[0] <= cfg_data;
        thb_pkg::REG_TEX_B:    tex_r[1] <= cfg_data;
        thb_pkg::REG_TEX_C:    tex_r[2] <= cfg_data;
        thb_pkg::REG_HIT_TOL:  tol_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [VXW-1:0]         vx   [3];
  logic signed [CB-1:0]   vert [3][3];
  logic signed [CB-1:0]   pt   [3];
  logic signed [TB-1:0]   tx   [3][2];

  for (genvar g = 0; g < 3; g++) begin : g_fields
    assign vx[g] = VXW'(vtx_r[g]);
    assign pt[g] = in_tdata[g*CB +: CB];
    for (genvar i = 0; i < 3; i++) begin : g_coord
      assign vert[g][i] = vx[g][i*CB +: CB];
    end
    for (genvar k = 0; k < 2; k++) begin : g_tex
      assign tx[g][k] = tex_r[g][k*TB +: TB];
    end
  end

  // ---------------- stage 1: edge and point vectors ----------------
  // qa qb qc e0 e1 e2
  logic signed [DW-1:0] vec_r [6][3];

  for (genvar i = 0; i < 3; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        vec_r[0][i] <= DW'(vert[0][i]) - DW'(pt[i]);
        vec_r[1][i] <= DW'(vert[1][i]) - DW'(pt[i]);
        vec_r[2][i] <= DW'(vert[2][i]) - DW'(pt[i]);
        vec_r[3][i] <= DW'(vert[1][i]) - DW'(vert[0][i]);
        vec_r[4][i] <= DW'(vert[2][i]) - DW'(vert[0][i]);
        vec_r[5][i] <= DW'(pt[i]) - DW'(vert[0][i]);
      end
    end
  end

  // ---------------- stages 2-3: cross and dot products ----------------
  logic signed [2*DW-1:0] cp_r [4][3][2];
  logic signed [2*DW-1:0] dp_r [5][3];
  logic signed [CRW-1:0]  cr_r [4][3];
  logic signed [DTW-1:0]  dt_r [5];

  for (genvar c = 0; c < 4; c++) begin : g_cross
    for (genvar k = 0; k < 3; k++) begin : g_comp
      localparam int IA = (k + 1) % 3;
      localparam int IB = (k + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          cp_r[c][k][0] <= vec_r[CP_A[c]][IA] * vec_r[CP_B[c]][IB];
          cp_r[c][k][1] <= vec_r[CP_A[c]][IB] * vec_r[CP_B[c]][IA];
          cr_r[c][k]    <= CRW'(cp_r[c][k][0]) - CRW'(cp_r[c][k][1]);
        end
      end
    end
  end

  for (genvar d = 0; d < 5; d++) begin : g_dot
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dp_r[d][i] <= vec_r[DP_A[d]][i] * vec_r[DP_B[d]][i];
        end
        dt_r[d] <= DTW'(dp_r[d][0]) + DTW'(dp_r[d][1]) + DTW'(dp_r[d][2]);
      end
    end
  end

  // ---------------- stages 4-5: squares and Gram products ----------------
  logic signed [SQW-1:0] sq_w [4][3];
  logic signed [DMW-1:0] dm_w [6];

  for (genvar c = 0; c < 4; c++) begin : g_sq
    for (genvar k = 0; k < 3; k++) begin : g_comp
      thb_smul #(.AW(CRW), .BW(CRW)) u_sq (
        .clk (clk),
        .en  (en),
        .a   (cr_r[c][k]),
        .b   (cr_r[c][k]),
        .p   (sq_w[c][k])
      );
    end
  end

  for (genvar m = 0; m < 6; m++) begin : g_dm
    thb_smul #(.AW(DTW), .BW(DTW)) u_dm (
      .clk (clk),
      .en  (en),
      .a   (dt_r[DM_A[m]]),
      .b   (dt_r[DM_B[m]]),
      .p   (dm_w[m])
    );
  end

  // ---------------- stage 6: norms squared, den, nb, nc ----------------
  logic [NW-1:0]         nsum_r [4];
  logic signed [DNS-1:0] den_r, nb_r, nc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        nsum_r[c] <= NW'(sq_w[c][0][SQW-1:0]) + NW'(sq_w[c][1][SQW-1:0]) +
                     NW'(sq_w[c][2][SQW-1:0]);
      end
      den_r <= DNS'(dm_w[0]) - DNS'(dm_w[1]);
      nb_r  <= DNS'(dm_w[2]) - DNS'(dm_w[3]);
      nc_r  <= DNS'(dm_w[4]) - DNS'(dm_w[5]);
    end
  end

  // ---------------- square root chain: one result bit per stage ----------------
  logic [NW-1:0]         sn_r    [RW][4];
  logic [REMW-1:0]       srem_r  [RW][4];
  logic [RW-1:0]         sroot_r [RW][4];
  logic signed [DNS-1:0] sden_r  [RW];
  logic signed [DNS-1:0] snb_r   [RW];
  logic signed [DNS-1:0] snc_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    for (genvar c = 0; c < 4; c++) begin : g_lane
      logic [NW-1:0]   n_in;
      logic [REMW-1:0] rem_in;
      logic [RW-1:0]   root_in;
      logic [TWW-1:0]  t;
      logic [TWW-1:0]  trial;
      logic            take;

      if (k == 0) begin : g_first
        assign n_in    = nsum_r[c];
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign n_in    = sn_r[k-1][c];
        assign rem_in  = srem_r[k-1][c];
        assign root_in = sroot_r[k-1][c];
      end

      assign t     = {rem_in, n_in[NW-1 -: 2]};
      assign trial = TWW'({root_in, 2'b01});
      assign take  = t >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          sn_r[k][c]    <= n_in << 2;
          srem_r[k][c]  <= take ? REMW'(t - trial) : REMW'(t);
          sroot_r[k][c] <= {root_in[RW-2:0], take};
        end
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          sden_r[k] <= den_r;
          snb_r[k]  <= nb_r;
          snc_r[k]  <= nc_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          sden_r[k] <= sden_r[k-1];
          snb_r[k]  <= snb_r[k-1];
          snc_r[k]  <= snc_r[k-1];
        end
      end
    end
  end

  // ---------------- area compare, numerator products ----------------
  logic [RW-2:0]         area [4];
  logic                  in1_r, in2_r;
  logic signed [DNS-1:0] den1_r, den2_r;

  for (genvar c = 0; c < 4; c++) begin : g_area
    assign area[c] = sroot_r[RW-1][c][RW-1:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in1_r  <= (AW2'(area[0]) + AW2'(area[1]) + AW2'(area[2])) <=
                (AW2'(area[3]) + AW2'(tol_r));
      den1_r <= sden_r[RW-1];
      in2_r  <= in1_r;
      den2_r <= den1_r;
    end
  end

  // products nb*(tb-ta), nc*(tc-ta) for u then v
  logic signed [TDW-1:0]     tdiff [4];
  logic signed [DNS+TDW-1:0] nm_w  [4];

  for (genvar k = 0; k < 2; k++) begin : g_num
    assign tdiff[2*k]   = TDW'(tx[1][k]) - TDW'(tx[0][k]);
    assign tdiff[2*k+1] = TDW'(tx[2][k]) - TDW'(tx[0][k]);

    thb_smul #(.AW(DNS), .BW(TDW)) u_nb (
      .clk (clk),
      .en  (en),
      .a   (snb_r[RW-1]),
      .b   (tdiff[2*k]),
      .p   (nm_w[2*k])
    );

    thb_smul #(.AW(DNS), .BW(TDW)) u_nc (
      .clk (clk),
      .en  (en),
      .a   (snc_r[RW-1]),
      .b   (tdiff[2*k+1]),
      .p   (nm_w[2*k+1])
    );
  end

  // ---------------- dividend setup: |num| + den/2 ----------------
  logic [XW-1:0]   x_r   [2];
  logic            neg_r [2];
  logic            ovf_r [2];
  logic            in3_r;
  logic            deg3_r;
  logic [DENW-1:0] den3_r;

  for (genvar k = 0; k < 2; k++) begin : g_dvd
    logic signed [NUMW-1:0] num;
    logic [NUMW-1:0]        mag;
    logic [XW-1:0]          xv;

    assign num = NUMW'(nm_w[2*k]) + NUMW'(nm_w[2*k+1]);
    assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    assign xv  = XW'(mag) + XW'(den2_r[DENW-1:0] >> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= xv;
        neg_r[k] <= num[NUMW-1];
        // quotient would need more than QB bits
        ovf_r[k] <= (xv >> QB) >= XW'(den2_r[DENW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in3_r  <= in2_r;
      deg3_r <= den2_r == '0;
      den3_r <= den2_r[DENW-1:0];
    end
  end

  // ---------------- restoring divider: one quotient bit per stage ----------------
  logic [QB-1:0]   dxl_r  [QB][2];
  logic [DENW-1:0] drem_r [QB][2];
  logic [QB-1:0]   dq_r   [QB][2];
  logic            dneg_r [QB][2];
  logic            dovf_r [QB][2];
  logic [DENW-1:0] dden_r [QB];
  logic            din_r  [QB];
  logic            ddeg_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DENW-1:0] den_in;

    if (j == 0) begin : g_first
      assign den_in = den3_r;
      always_ff @(posedge clk) begin
        if (en) begin
          dden_r[j] <= den3_r;
          din_r[j]  <= in3_r;
          ddeg_r[j] <= deg3_r;
        end
      end
    end else begin : g_next
      assign den_in = dden_r[j-1];
      always_ff @(posedge clk) begin
        if (en) begin
          dden_r[j] <= dden_r[j-1];
          din_r[j]  <= din_r[j-1];
          ddeg_r[j] <= ddeg_r[j-1];
        end
      end
    end

    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [QB-1:0]   xl_in;
      logic [DENW-1:0] rem_in;
      logic [QB-1:0]   q_in;
      logic            neg_in, ovf_in;
      logic [DENW:0]   t;
      logic            take;

      if (j == 0) begin : g_first
        assign xl_in  = x_r[k][QB-1:0];
        assign rem_in = DENW'(x_r[k] >> QB);
        assign q_in   = '0;
        assign neg_in = neg_r[k];
        assign ovf_in = ovf_r[k];
      end else begin : g_next
        assign xl_in  = dxl_r[j-1][k];
        assign rem_in = drem_r[j-1][k];
        assign q_in   = dq_r[j-1][k];
        assign neg_in = dneg_r[j-1][k];
        assign ovf_in = dovf_r[j-1][k];
      end

      assign t    = {rem_in, xl_in[QB-1-j]};
      assign take = t >= {1'b0, den_in};

      always_ff @(posedge clk) begin
        if (en) begin
          dxl_r[j][k]  <= xl_in;
          drem_r[j][k] <= take ? DENW'(t - {1'b0, den_in}) : DENW'(t);
          dq_r[j][k]   <= {q_in[QB-2:0], take};
          dneg_r[j][k] <= neg_in;
          dovf_r[j][k] <= ovf_in;
        end
      end
    end
  end

  // ---------------- output stage: add base, saturate, zero if degenerate ----------------
  logic [TB-1:0] tex_w [2];

  for (genvar k = 0; k < 2; k++) begin : g_out
    logic [QB-1:0]          q;
    logic signed [RXW-1:0]  qx;
    logic signed [RXW-1:0]  r;
    logic signed [RXW-1:0]  res;
    logic                   sat;

    assign q   = dq_r[QB-1][k];
    assign qx  = RXW'(q);
    assign sat = dovf_r[QB-1][k] || (q > QLIM);
    assign r   = RXW'(tx[0][k]) + (dneg_r[QB-1][k] ? -qx : qx);

    always_comb begin
      if (ddeg_r[QB-1]) begin
        res = '0;
      end else if (sat) begin
        res = dneg_r[QB-1][k] ? TMIN : TMAX;
      end else if (r > TMAX) begin
        res = TMAX;
      end else if (r < TMIN) begin
        res = TMIN;
      end else begin
        res = r;
      end
    end

    assign tex_w[k] = res[TB-1:0];
  end

  logic [OUT_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= OUT_W'({tex_w[1], tex_w[0], ddeg_r[QB-1], din_r[QB-1]});
    end
  end

  assign out_tdata = out_r;

endmodule

### rtl/thb_check.sv
// ----------------------------------------------------------------------------
// thb_check
// Port-level checks for the triangle hit / barycentric UV core.
// ----------------------------------------------------------------------------
module thb_check #(
  parameter int TEX_BITS = thb_pkg::TEX_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2+2*TEX_BITS+7)/8)*8-1:0]    out_tdata
);

  // a result waiting for its transfer stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // degenerate triangle gives zero texture coordinates
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[2 +: 2*TEX_BITS] == '0)
    else $error("degenerate result with nonzero texture");

  // an empty output stage never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a draining output always lets a new point in
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind triangle_hit_and_barycentric_uv_core thb_check #(.TEX_BITS(TEX_BITS)) u_thb_check (.*);
